// File: hw/rtl/grc_pkg.sv
// Shared types and constants for the grid ray-cast wall column core.
// Used by the map RAM, the divider, the top level and the port checker.
package grc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int MAP_BITS  = 6;
    localparam int MAP_SIZE  = 1 << MAP_BITS;
    localparam int TEX_BITS  = 6;
    localparam int COORD_W   = MAP_BITS + 2;
    localparam int ADDR_W    = 2 * MAP_BITS;

    localparam int DIV_NW = 40;
    localparam int DIV_DW = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 22;

    localparam logic [CFG_IDX_W-1:0] CFG_POS_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_X  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_Y  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd7;

    localparam logic FUNC_MAP_WRITE = 1'b0;
    localparam logic FUNC_CAST      = 1'b1;

    localparam logic [23:0] PERP_MAX   = 24'hFFFFFF;
    localparam logic [23:0] STEP_MAX   = 24'hFFFFFF;
    localparam logic [21:0] TSTART_MAX = 22'h3FFFFF;
    localparam logic [30:0] LINE_MAX   = 31'h7FFFFFFF;
    localparam logic [36:0] DELTA_MAX  = 37'h10_0000_0000;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CAM_GO,
        S_RAYX,
        S_RAYY,
        S_DX_GO,
        S_DY_GO,
        S_SDX,
        S_SDY,
        S_WALK,
        S_CHECK,
        S_PERP_GO,
        S_LINE_GO,
        S_ROWS,
        S_TEX,
        S_STEP_GO,
        S_TPOS,
        S_DIV_WAIT,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        DK_CAM,
        DK_DX,
        DK_DY,
        DK_PERP,
        DK_LINE,
        DK_STEP
    } div_kind_t;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_NW-1:0] quo;
    } div_rsp_t;

endpackage

// File: hw/rtl/grc_map_ram.sv
// Wall bit map: one-bit synchronous RAM, one write and one registered read port.
// Depends on grc_pkg for the address width.
module grc_map_ram (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [grc_pkg::ADDR_W-1:0] wr_addr,
    input  logic                      wr_data,
    input  logic                      rd_en,
    input  logic [grc_pkg::ADDR_W-1:0] rd_addr,
    output logic                      rd_data
);
    import grc_pkg::*;

    logic mem [0:(1 << ADDR_W)-1];
    logic rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/grc_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, unsigned.
// Depends on grc_pkg for the request and response structs.
module grc_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  grc_pkg::div_req_t req,
    output grc_pkg::div_rsp_t rsp
);
    import grc_pkg::*;

    localparam int CNT_W = $clog2(DIV_NW + 1);

    logic [DIV_NW-1:0] quo_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW-1:0] den_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIV_DW:0]   shifted;
    logic              fits;

    assign shifted = {rem_reg, quo_reg[DIV_NW-1]};
    assign fits    = shifted >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (!busy_reg && req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_NW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!busy_reg && req.start) begin
            quo_reg <= req.num;
            rem_reg <= '0;
            den_reg <= req.den;
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= DIV_DW'(shifted - {1'b0, den_reg});
                quo_reg <= {quo_reg[DIV_NW-2:0], 1'b1};
            end else begin
                rem_reg <= shifted[DIV_DW-1:0];
                quo_reg <= {quo_reg[DIV_NW-2:0], 1'b0};
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

// File: hw/rtl/grid_raycast_wall_column_core.sv
// Grid ray-cast wall column core: map RAM, shared divider and cast sequencer.
// A cast runs up to six divisions (a zero divisor skips one, a miss skips the last
// three), plus one RAM read per grid cell walked. Map writes are taken while idle.
// One item is in work at a time; one result may wait.
// Reset (aresetn, synchronous, active low) restores the configuration defaults;
// the map RAM is not cleared and must be written before it is cast against.
module grid_raycast_wall_column_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [grc_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [grc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_func,
    input  logic [5:0]                        s_cell_row,
    input  logic [5:0]                        s_cell_col,
    input  logic                              s_wall_flag,
    input  logic [10:0]                       s_screen_column,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [10:0]                       m_column_out,
    output logic [10:0]                       m_draw_start,
    output logic [10:0]                       m_draw_end,
    output logic [1:0]                        m_wall_side,
    output logic [1:0]                        m_texture_id,
    output logic [5:0]                        m_texture_col,
    output logic [23:0]                       m_texture_step,
    output logic [21:0]                       m_texture_start,
    output logic [23:0]                       m_perp_distance,
    output logic                              m_no_hit
);
    import grc_pkg::*;

    // configuration
    logic [21:0]        pos_x_reg, pos_y_reg;
    logic signed [17:0] dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;
    logic [11:0]        width_reg, height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg   <= 22'd2162688;
            pos_y_reg   <= 22'd2162688;
            dir_x_reg   <= -18'sd65536;
            dir_y_reg   <= 18'sd0;
            plane_x_reg <= 18'sd0;
            plane_y_reg <= 18'sd43254;
            width_reg   <= 12'd640;
            height_reg  <= 12'd480;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_POS_X:   pos_x_reg   <= cfg_wdata;
                CFG_POS_Y:   pos_y_reg   <= cfg_wdata;
                CFG_DIR_X:   dir_x_reg   <= cfg_wdata[17:0];
                CFG_DIR_Y:   dir_y_reg   <= cfg_wdata[17:0];
                CFG_PLANE_X: plane_x_reg <= cfg_wdata[17:0];
                CFG_PLANE_Y: plane_y_reg <= cfg_wdata[17:0];
                CFG_WIDTH:   width_reg   <= cfg_wdata[11:0];
                CFG_HEIGHT:  height_reg  <= cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    logic [11:0] w_eff, h_eff;
    assign w_eff = (width_reg == '0) ? 12'd1 : width_reg;
    assign h_eff = (height_reg == '0) ? 12'd1 : height_reg;

    // control
    state_t    state_reg, state_next;
    div_kind_t kind_reg;
    div_req_t  div_req;
    div_rsp_t  div_rsp;

    logic s_acc, cast_acc, map_acc;
    assign s_ready  = (state_reg == S_IDLE);
    assign s_acc    = s_valid && s_ready;
    assign cast_acc = s_acc && (s_func == FUNC_CAST);
    assign map_acc  = s_acc && (s_func == FUNC_MAP_WRITE);

    // working registers
    logic [10:0]        col_reg;
    logic signed [29:0] cam_reg;
    logic signed [32:0] rdx_reg, rdy_reg;
    logic [36:0]        dx_reg, dy_reg;
    logic [44:0]        sdx_reg, sdy_reg;
    logic [COORD_W-1:0] mx_reg, my_reg;
    logic [1:0]         side_reg;
    logic               nohit_reg;
    logic [23:0]        perp_reg;
    logic [30:0]        line_reg;
    logic [11:0]        ds_reg, de_reg;
    logic [30:0]        coef_reg;
    logic [5:0]         texc_reg;
    logic [23:0]        step_reg;
    logic [21:0]        tpos_reg;

    // map RAM
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic              ram_rd_data;

    grc_map_ram u_map (
        .aclk    (aclk),
        .wr_en   (map_acc),
        .wr_addr ({s_cell_row, s_cell_col}),
        .wr_data (s_wall_flag),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    grc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // magnitudes of the ray
    logic [32:0] rdx_neg, rdy_neg;
    logic [31:0] adx, ady;
    assign rdx_neg = -rdx_reg;
    assign rdy_neg = -rdy_reg;
    assign adx     = rdx_reg[32] ? rdx_neg[31:0] : rdx_reg[31:0];
    assign ady     = rdy_reg[32] ? rdy_neg[31:0] : rdy_reg[31:0];

    // ray direction: view + plane * cam
    logic signed [17:0] plane_sel, view_sel;
    logic signed [47:0] ray_prod;
    logic signed [32:0] ray_sum;
    assign plane_sel = (state_reg == S_RAYX) ? plane_x_reg : plane_y_reg;
    assign view_sel  = (state_reg == S_RAYX) ? dir_x_reg : dir_y_reg;
    assign ray_prod  = plane_sel * cam_reg;
    assign ray_sum   = {{15{view_sel[17]}}, view_sel} + {ray_prod[47], ray_prod[47:16]};

    // initial side distance
    logic [21:0] pos_sel;
    logic        neg_sel;
    logic [16:0] cell_frac;
    logic [36:0] delta_sel;
    logic [53:0] side_prod;
    assign pos_sel   = (state_reg == S_SDX) ? pos_x_reg : pos_y_reg;
    assign neg_sel   = (state_reg == S_SDX) ? rdx_reg[32] : rdy_reg[32];
    assign delta_sel = (state_reg == S_SDX) ? dx_reg : dy_reg;
    assign cell_frac = neg_sel ? {1'b0, pos_sel[FRAC_BITS-1:0]}
                               : 17'h10000 - {1'b0, pos_sel[FRAC_BITS-1:0]};
    assign side_prod = cell_frac * delta_sel;

    // one DDA step
    logic               step_x;
    logic [COORD_W-1:0] mx_step, my_step;
    logic               leaves;
    assign step_x  = sdx_reg < sdy_reg;
    assign mx_step = step_x ? (rdx_reg[32] ? mx_reg - 1'b1 : mx_reg + 1'b1) : mx_reg;
    assign my_step = step_x ? my_reg : (rdy_reg[32] ? my_reg - 1'b1 : my_reg + 1'b1);
    assign leaves  = (mx_step[COORD_W-1:MAP_BITS] != '0) ||
                     (my_step[COORD_W-1:MAP_BITS] != '0);
    assign ram_rd_en   = (state_reg == S_WALK) && !leaves;
    assign ram_rd_addr = {mx_step[MAP_BITS-1:0], my_step[MAP_BITS-1:0]};

    // distance numerator at the hit face
    logic               side_is_x;
    logic signed [24:0] hit_num;
    logic [24:0]        hit_num_neg;
    logic [23:0]        hit_abs;
    logic [31:0]        adr;
    assign side_is_x = !side_reg[0];
    assign hit_num = side_is_x
        ? $signed({3'b0, mx_reg[MAP_BITS-1:0], 16'b0}) - $signed({3'b0, pos_x_reg})
          + $signed({8'b0, rdx_reg[32], 16'b0})
        : $signed({3'b0, my_reg[MAP_BITS-1:0], 16'b0}) - $signed({3'b0, pos_y_reg})
          + $signed({8'b0, rdy_reg[32], 16'b0});
    assign hit_num_neg = -hit_num;
    assign hit_abs     = hit_num[24] ? hit_num_neg[23:0] : hit_num[23:0];
    assign adr         = side_is_x ? ady == ady && 1'b1 ? adx : adx : ady;

    // wall slice rows
    logic [29:0] half_line;
    logic [10:0] half_h;
    logic [30:0] de_sum;
    assign half_line = line_reg[30:1];
    assign half_h    = h_eff[11:1];
    assign de_sum    = {1'b0, half_line} + 31'(half_h);

    // texture column from the wall hit fraction
    logic [31:0]          ray_lo;
    logic [55:0]          tex_prod;
    logic [FRAC_BITS-1:0] hit_frac;
    logic [TEX_BITS-1:0]  texc;
    assign ray_lo   = side_is_x ? rdy_reg[31:0] : rdx_reg[31:0];
    assign tex_prod = perp_reg * ray_lo;
    assign hit_frac = (side_is_x ? pos_y_reg[FRAC_BITS-1:0] : pos_x_reg[FRAC_BITS-1:0])
                      + tex_prod[31:16];
    assign texc     = hit_frac[FRAC_BITS-1 -: TEX_BITS];

    logic [45:0] tpos_prod;
    assign tpos_prod = coef_reg[21:0] * step_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     if (cast_acc) state_next = S_CAM_GO;
            S_CAM_GO:   state_next = S_DIV_WAIT;
            S_RAYX:     state_next = S_RAYY;
            S_RAYY:     state_next = S_DX_GO;
            S_DX_GO:    state_next = (adx != '0) ? S_DIV_WAIT : S_DY_GO;
            S_DY_GO:    state_next = (ady != '0) ? S_DIV_WAIT : S_SDX;
            S_SDX:      state_next = S_SDY;
            S_SDY:      state_next = S_WALK;
            S_WALK:     state_next = leaves ? S_DONE : S_CHECK;
            S_CHECK:    state_next = ram_rd_data ? S_PERP_GO : S_WALK;
            S_PERP_GO:  state_next = (adr != '0) ? S_DIV_WAIT : S_LINE_GO;
            S_LINE_GO:  state_next = (perp_reg != '0) ? S_DIV_WAIT : S_ROWS;
            S_ROWS:     state_next = S_TEX;
            S_TEX:      state_next = S_STEP_GO;
            S_STEP_GO:  state_next = (line_reg != '0) ? S_DIV_WAIT : S_TPOS;
            S_TPOS:     state_next = S_DONE;
            S_DIV_WAIT: begin
                if (div_rsp.done) begin
                    unique case (kind_reg)
                        DK_CAM:  state_next = S_RAYX;
                        DK_DX:   state_next = S_DY_GO;
                        DK_DY:   state_next = S_SDX;
                        DK_PERP: state_next = S_LINE_GO;
                        DK_LINE: state_next = S_ROWS;
                        DK_STEP: state_next = S_TPOS;
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_DONE:     if (!m_valid || m_ready) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // divider requests
    always_comb begin
        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = '0;
        unique case (state_reg)
            S_CAM_GO: begin
                div_req.start = 1'b1;
                div_req.num   = DIV_NW'({col_reg, 17'b0});
                div_req.den   = DIV_DW'(w_eff);
            end
            S_DX_GO: begin
                div_req.start = (adx != '0);
                div_req.num   = DIV_NW'(1) << (2 * FRAC_BITS);
                div_req.den   = adx;
            end
            S_DY_GO: begin
                div_req.start = (ady != '0);
                div_req.num   = DIV_NW'(1) << (2 * FRAC_BITS);
                div_req.den   = ady;
            end
            S_PERP_GO: begin
                div_req.start = (adr != '0);
                div_req.num   = DIV_NW'({hit_abs, 16'b0});
                div_req.den   = adr;
            end
            S_LINE_GO: begin
                div_req.start = (perp_reg != '0);
                div_req.num   = DIV_NW'({h_eff, 16'b0});
                div_req.den   = DIV_DW'(perp_reg);
            end
            S_STEP_GO: begin
                div_req.start = (line_reg != '0);
                div_req.num   = DIV_NW'(1) << (TEX_BITS + FRAC_BITS);
                div_req.den   = DIV_DW'(line_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (cast_acc) begin
                    col_reg   <= s_screen_column;
                    nohit_reg <= 1'b0;
                end
            end
            S_CAM_GO:  kind_reg <= DK_CAM;
            S_RAYX:    rdx_reg  <= ray_sum;
            S_RAYY:    rdy_reg  <= ray_sum;
            S_DX_GO: begin
                kind_reg <= DK_DX;
                if (adx == '0) dx_reg <= DELTA_MAX;
            end
            S_DY_GO: begin
                kind_reg <= DK_DY;
                if (ady == '0) dy_reg <= DELTA_MAX;
            end
            S_SDX: begin
                sdx_reg <= 45'(side_prod[53:16]);
                mx_reg  <= COORD_W'(pos_x_reg[21:16]);
            end
            S_SDY: begin
                sdy_reg <= 45'(side_prod[53:16]);
                my_reg  <= COORD_W'(pos_y_reg[21:16]);
            end
            S_WALK: begin
                if (step_x) begin
                    sdx_reg  <= sdx_reg + 45'(dx_reg);
                    side_reg <= rdx_reg[32] ? 2'd0 : 2'd2;
                end else begin
                    sdy_reg  <= sdy_reg + 45'(dy_reg);
                    side_reg <= rdy_reg[32] ? 2'd1 : 2'd3;
                end
                mx_reg <= mx_step;
                my_reg <= my_step;
                if (leaves) nohit_reg <= 1'b1;
            end
            S_PERP_GO: begin
                kind_reg <= DK_PERP;
                if (adr == '0) perp_reg <= PERP_MAX;
            end
            S_LINE_GO: begin
                kind_reg <= DK_LINE;
                if (perp_reg == '0) line_reg <= LINE_MAX;
            end
            S_ROWS: begin
                if ({1'b0, half_line} >= 31'(half_h)) begin
                    ds_reg   <= '0;
                    coef_reg <= {1'b0, half_line} - 31'(half_h);
                end else begin
                    ds_reg   <= 12'(half_h - 11'(half_line));
                    coef_reg <= '0;
                end
                de_reg <= (de_sum >= 31'(h_eff)) ? h_eff - 1'b1 : de_sum[11:0];
            end
            S_TEX: begin
                texc_reg <= (side_reg == 2'd1 || side_reg == 2'd2) ? ~texc : texc;
            end
            S_STEP_GO: begin
                kind_reg <= DK_STEP;
                if (line_reg == '0) step_reg <= STEP_MAX;
            end
            S_TPOS: begin
                if (coef_reg > 31'(TSTART_MAX) || tpos_prod > 46'(TSTART_MAX)) begin
                    tpos_reg <= TSTART_MAX;
                end else begin
                    tpos_reg <= tpos_prod[21:0];
                end
            end
            S_DIV_WAIT: begin
                if (div_rsp.done) begin
                    case (kind_reg)
                        DK_CAM:  cam_reg  <= $signed({2'b0, div_rsp.quo[27:0]}) - 30'sd65536;
                        DK_DX:   dx_reg   <= div_rsp.quo[36:0];
                        DK_DY:   dy_reg   <= div_rsp.quo[36:0];
                        DK_PERP: perp_reg <= (div_rsp.quo > DIV_NW'(PERP_MAX))
                                             ? PERP_MAX : div_rsp.quo[23:0];
                        DK_LINE: line_reg <= div_rsp.quo[30:0];
                        DK_STEP: step_reg <= (div_rsp.quo > DIV_NW'(STEP_MAX))
                                             ? STEP_MAX : div_rsp.quo[23:0];
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    // result register
    logic m_valid_reg;
    logic load_out;
    assign load_out = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_column_out    <= col_reg;
            m_no_hit        <= nohit_reg;
            m_draw_start    <= nohit_reg ? '0 : ds_reg[10:0];
            m_draw_end      <= nohit_reg ? '0 : (de_reg[11] ? 11'd2047 : de_reg[10:0]);
            m_wall_side     <= nohit_reg ? '0 : side_reg;
            m_texture_id    <= nohit_reg ? '0 : {side_reg[0], side_reg[1]};
            m_texture_col   <= nohit_reg ? '0 : texc_reg;
            m_texture_step  <= nohit_reg ? '0 : step_reg;
            m_texture_start <= nohit_reg ? '0 : tpos_reg;
            m_perp_distance <= nohit_reg ? '0 : perp_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// File: hw/rtl/grc_checker.sv
// Port-level checker for the ray-cast core, bound to the top level.
// Depends on grc_pkg for the function codes.
module grc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_func,
    input logic        m_valid,
    input logic        m_ready,
    input logic [10:0] m_column_out,
    input logic [10:0] m_draw_start,
    input logic [10:0] m_draw_end,
    input logic [1:0]  m_wall_side,
    input logic [1:0]  m_texture_id,
    input logic [23:0] m_perp_distance,
    input logic        m_no_hit
);
    import grc_pkg::*;

    // a waiting result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_column_out))
        else $error("result beat changed while stalled");

    a_cast_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_func == FUNC_CAST |=> !s_ready)
        else $error("input taken while a cast is in work");

    a_nohit_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_no_hit |-> m_draw_start == '0 && m_perp_distance == '0)
        else $error("miss result carries nonzero fields");

    a_tex_id: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_no_hit |-> m_texture_id == {m_wall_side[0], m_wall_side[1]})
        else $error("texture id does not follow the face");

    a_rows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_no_hit |-> m_draw_start <= m_draw_end)
        else $error("slice start beyond slice end");

endmodule

bind grid_raycast_wall_column_core grc_checker u_grc_checker (.*);
